// File: src/dmwbc_pkg.sv
// Shared sizes, types and codes for the direct-mapped write-back cache.
package dmwbc_pkg;

  localparam int unsigned LINES          = 32;
  localparam int unsigned BYTES_PER_LINE = 8;
  localparam int unsigned ADDRESS_BITS   = 16;

  localparam int unsigned OFF_W   = $clog2(BYTES_PER_LINE);
  localparam int unsigned LINE_W  = $clog2(LINES);
  localparam int unsigned TAG_W   = ADDRESS_BITS - LINE_W - OFF_W;
  localparam int unsigned DATA_W  = 8 * BYTES_PER_LINE;
  localparam int unsigned ENTRY_W = TAG_W + DATA_W;
  localparam int unsigned MEM_IDX_W = ADDRESS_BITS - OFF_W;
  localparam int unsigned MEM_LINES = 2 ** MEM_IDX_W;

  typedef logic [BYTES_PER_LINE-1:0][7:0] line_t;
  typedef logic [TAG_W-1:0]               tag_t;
  typedef logic [LINE_W-1:0]              idx_t;
  typedef logic [OFF_W-1:0]               off_t;
  typedef logic [MEM_IDX_W-1:0]           mem_idx_t;

  // One cache entry: stored tag above the line bytes.
  typedef struct packed {
    tag_t  tag;
    line_t bytes;
  } entry_t;

  localparam logic MODE_READ  = 1'b0;
  localparam logic MODE_WRITE = 1'b1;

endpackage

// File: src/dmwbc_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module dmwbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: src/direct_mapped_write_back_cache.sv
// Top level of the direct-mapped write-back byte cache with its backing memory.
//
//  channel   direction  handshake           word
//  access    in         start_i / busy_o    mode_i, address_i, write_byte_i
//  result    out        valid_o (strobe)    read_byte_o, hit_o, was_dirty_o
//
// Every access reads the cache entry and the backing line when it is taken,
// then merges, writes back and refills in ST_LOOKUP. Both memories have
// registered read ports; busy_o holds the next word off until the write has
// landed, so no forwarding is needed, and no new word is taken before then.
// After reset the backing memory is cleared one line per cycle, all 8192 lines,
// with busy_o high. A read result shows in the cycle after ST_LOOKUP;
// the receiver cannot stall it.
module direct_mapped_write_back_cache (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  output logic       busy_o,
  input  logic       mode_i,
  input  logic [dmwbc_pkg::ADDRESS_BITS-1:0] address_i,
  input  logic [7:0] write_byte_i,
  output logic       valid_o,
  output logic [7:0] read_byte_o,
  output logic       hit_o,
  output logic       was_dirty_o
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;

  logic [1:0] state_q, state_d;
  dmwbc_pkg::mem_idx_t clr_q, clr_d;
  logic [dmwbc_pkg::LINES-1:0] valid_q, valid_d;
  logic [dmwbc_pkg::LINES-1:0] dirty_q, dirty_d;

  logic           mode_q;
  dmwbc_pkg::tag_t tag_q;
  dmwbc_pkg::idx_t line_q;
  dmwbc_pkg::off_t off_q;
  logic [7:0]     wbyte_q;

  logic       res_valid_q;
  logic [7:0] res_byte_q;
  logic       res_hit_q;
  logic       res_dirty_q;

  logic accept;
  dmwbc_pkg::entry_t cache_rdata, cache_wdata;
  dmwbc_pkg::line_t  back_rdata;
  logic              back_we;
  dmwbc_pkg::mem_idx_t back_waddr;
  dmwbc_pkg::line_t  back_wdata;
  logic              hit, old_dirty;
  dmwbc_pkg::line_t  base_line, new_line;

  assign accept = start_i && !busy_o;
  assign busy_o = (state_q != ST_IDLE);

  dmwbc_ram #(
    .WIDTH(dmwbc_pkg::ENTRY_W),
    .DEPTH(dmwbc_pkg::LINES)
  ) u_cache_ram (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_LOOKUP),
    .waddr_i(line_q),
    .wdata_i(cache_wdata),
    .re_i   (accept),
    .raddr_i(address_i[dmwbc_pkg::OFF_W +: dmwbc_pkg::LINE_W]),
    .rdata_o(cache_rdata)
  );

  dmwbc_ram #(
    .WIDTH(dmwbc_pkg::DATA_W),
    .DEPTH(dmwbc_pkg::MEM_LINES)
  ) u_backing_ram (
    .clk_i  (clk_i),
    .we_i   (back_we),
    .waddr_i(back_waddr),
    .wdata_i(back_wdata),
    .re_i   (accept),
    .raddr_i(address_i[dmwbc_pkg::OFF_W +: dmwbc_pkg::MEM_IDX_W]),
    .rdata_o(back_rdata)
  );

  // A miss takes the backing line read alongside the entry; a dirty victim goes
  // back through the write port in the same cycle, so no read is needed then.
  always_comb begin
    hit       = valid_q[line_q] && (cache_rdata.tag == tag_q);
    old_dirty = valid_q[line_q] && dirty_q[line_q];
    base_line = hit ? cache_rdata.bytes : back_rdata;
    new_line  = base_line;
    if (mode_q == dmwbc_pkg::MODE_WRITE) begin
      new_line[off_q] = wbyte_q;
    end
    cache_wdata.tag   = tag_q;
    cache_wdata.bytes = new_line;

    if (state_q == ST_CLEAR) begin
      back_we    = 1'b1;
      back_waddr = clr_q;
      back_wdata = '0;
    end else begin
      back_we    = (state_q == ST_LOOKUP) && !hit && old_dirty;
      back_waddr = {cache_rdata.tag, line_q};
      back_wdata = cache_rdata.bytes;
    end
  end

  always_comb begin
    state_d = state_q;
    clr_d   = clr_q;
    valid_d = valid_q;
    dirty_d = dirty_q;
    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == dmwbc_pkg::mem_idx_t'(dmwbc_pkg::MEM_LINES - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d         = ST_IDLE;
        valid_d[line_q] = 1'b1;
        if (mode_q == dmwbc_pkg::MODE_WRITE) begin
          dirty_d[line_q] = 1'b1;
        end else if (!hit) begin
          dirty_d[line_q] = 1'b0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      valid_q     <= '0;
      dirty_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      valid_q     <= valid_d;
      dirty_q     <= dirty_d;
      res_valid_q <= (state_q == ST_LOOKUP) && (mode_q == dmwbc_pkg::MODE_READ);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q  <= mode_i;
      tag_q   <= address_i[dmwbc_pkg::OFF_W + dmwbc_pkg::LINE_W +: dmwbc_pkg::TAG_W];
      line_q  <= address_i[dmwbc_pkg::OFF_W +: dmwbc_pkg::LINE_W];
      off_q   <= address_i[dmwbc_pkg::OFF_W-1:0];
      wbyte_q <= write_byte_i;
    end
    if (state_q == ST_LOOKUP) begin
      res_byte_q  <= new_line[off_q];
      res_hit_q   <= hit;
      res_dirty_q <= old_dirty;
    end
  end

  assign valid_o     = res_valid_q;
  assign read_byte_o = res_byte_q;
  assign hit_o       = res_hit_q;
  assign was_dirty_o = res_dirty_q;

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("accepted word did not make the block busy");

  a_result_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> ($past(state_q) == ST_LOOKUP) && ($past(mode_q) == dmwbc_pkg::MODE_READ))
    else $error("result strobe without a finished read");

  a_write_sets_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) && (mode_q == dmwbc_pkg::MODE_WRITE)
      |=> dirty_q[$past(line_q)] && valid_q[$past(line_q)])
    else $error("write left its line clean or invalid");

  a_no_writeback_on_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOKUP) && hit |-> !back_we)
    else $error("backing memory written on a hit");

endmodule
